// File: hw/rtl/fbecho_pkg.sv
package fbecho_pkg;

    localparam int STORE_DEPTH = 131072;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int DLY_W       = 17;
    localparam int CNT_W       = (ADDR_W + 1 > DLY_W) ? ADDR_W + 1 : DLY_W;

    localparam int SAMPLE_W    = 16;
    localparam int PCT_W       = 7;
    localparam int DEPTH_W     = 16;
    localparam int CFG_W       = 17;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_DELAY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH    = 2'd3;

    localparam logic [DLY_W-1:0]   DELAY_RST    = 17'd0;
    localparam logic [PCT_W-1:0]   FEEDBACK_RST = 7'd0;
    localparam logic [PCT_W-1:0]   VOLUME_RST   = 7'd100;
    localparam logic [DEPTH_W-1:0] DEPTH_RST    = 16'd16384;

    // divide by 100: exact for dividends below 2^DIV_IN_W
    localparam int DIV_IN_W    = 29;
    localparam int RECIP_W     = 30;
    localparam int RECIP_SHIFT = 36;
    localparam int PROD_W      = DIV_IN_W + RECIP_W;
    localparam int Q_W         = PROD_W - RECIP_SHIFT;
    localparam logic [RECIP_W-1:0] RECIP_100 = 30'd687194768;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_MIX,
        ST_VOL,
        ST_DEPTH,
        ST_FIN,
        ST_EMIT
    } state_t;

    // sign and magnitude to saturated 16-bit two's complement
    function automatic logic signed [SAMPLE_W-1:0] sat_sm(input logic neg,
                                                          input logic [Q_W-1:0] mag);
        logic [SAMPLE_W-1:0] v;
        if (neg) begin
            if (mag >= Q_W'(32768)) begin
                v = 16'h8000;
            end else begin
                v = ~mag[SAMPLE_W-1:0] + 16'd1;
            end
        end else begin
            if (mag > Q_W'(32767)) begin
                v = 16'h7fff;
            end else begin
                v = mag[SAMPLE_W-1:0];
            end
        end
        return signed'(v);
    endfunction

endpackage

// File: hw/rtl/feedback_echo_delay.sv
// Path: an accepted beat steps through READ, DIV, MIX and EMIT while the delay line fills,
// and through READ, DIV, MIX, VOL, DEPTH, DIV, FIN and EMIT once the echo path is active.
// A new beat is taken only once the sequencer is back in IDLE; the sequencer steps one
// divide-by-100 multiplier and the delay memory.
// Reset clears control state and loads the register defaults; no memory clearing pass:
// entries not yet written since reset read as zero via write position and wrap flag.
module feedback_echo_delay (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [fbecho_pkg::SAMPLE_W-1:0] sample_in,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [fbecho_pkg::SAMPLE_W-1:0] sample_out,
    input  logic                                cfg_we,
    input  logic [fbecho_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fbecho_pkg::CFG_W-1:0]        cfg_data
);
    import fbecho_pkg::*;

    state_t state_reg, state_next;

    logic [DLY_W-1:0]   delay_reg;
    logic [PCT_W-1:0]   fb_reg;
    logic [PCT_W-1:0]   vol_reg;
    logic [DEPTH_W-1:0] depth_reg;

    logic [ADDR_W-1:0]  pos_reg, pos_next;
    logic               wrapped_reg, wrapped_next;
    logic [CNT_W-1:0]   fill_cnt_reg, fill_cnt_next;
    logic               out_valid_reg, out_valid_next;

    logic signed [SAMPLE_W-1:0] x_reg, x_next;
    logic                       fill_reg, fill_next;
    logic                       old_ok_reg, old_ok_next;
    logic [ADDR_W-1:0]          wr_addr_reg, wr_addr_next;
    logic [DIV_IN_W-1:0]        div_in_reg, div_in_next;
    logic [PROD_W-1:0]          m_reg, m_next;
    logic                       sign_reg, sign_next;
    logic                       pass2_reg, pass2_next;
    logic [23:0]                new_mag_reg, new_mag_next;
    logic [30:0]                p1_reg, p1_next;
    logic signed [SAMPLE_W-1:0] res_reg, res_next;
    logic signed [SAMPLE_W-1:0] out_data_reg, out_data_next;

    logic [SAMPLE_W-1:0] mem [STORE_DEPTH];
    logic [SAMPLE_W-1:0] rdata_reg;
    logic                rd_en;
    logic                we;
    logic [SAMPLE_W-1:0] wdata;

    // read address and fill decision
    logic [CNT_W-1:0]  d_eff;
    logic [CNT_W:0]    rd_sum;
    logic [CNT_W:0]    rd_wrap;
    logic [ADDR_W-1:0] rd_addr;
    logic              fill_now;
    logic              pos_last;

    assign d_eff    = (CNT_W'(delay_reg) >= CNT_W'(STORE_DEPTH)) ? CNT_W'(STORE_DEPTH)
                                                                  : CNT_W'(delay_reg);
    assign rd_sum   = (CNT_W+1)'(pos_reg) + (CNT_W+1)'(STORE_DEPTH) - (CNT_W+1)'(d_eff);
    assign rd_wrap  = (rd_sum >= (CNT_W+1)'(STORE_DEPTH)) ? rd_sum - (CNT_W+1)'(STORE_DEPTH)
                                                          : rd_sum;
    assign rd_addr  = rd_wrap[ADDR_W-1:0];
    assign fill_now = fill_cnt_reg < d_eff;
    assign pos_last = pos_reg == ADDR_W'(STORE_DEPTH - 1);

    // operand decode
    logic signed [SAMPLE_W-1:0] old_s;
    logic                       old_neg, x_neg;
    logic [SAMPLE_W-1:0]        old_mag, x_mag;
    logic [22:0]                mul1;
    logic [Q_W-1:0]             q;
    logic signed [23:0]         t_s;
    logic signed [24:0]         new_s;
    logic [24:0]                new_abs;
    logic                       new_neg;
    logic [46:0]                p2;

    assign old_s   = old_ok_reg ? signed'(rdata_reg) : '0;
    assign old_neg = old_s[SAMPLE_W-1];
    assign old_mag = old_neg ? (~unsigned'(old_s) + 16'd1) : unsigned'(old_s);
    assign x_neg   = x_reg[SAMPLE_W-1];
    assign x_mag   = x_neg ? (~unsigned'(x_reg) + 16'd1) : unsigned'(x_reg);
    assign mul1    = fill_reg ? 23'(x_mag) * 23'(vol_reg) : 23'(old_mag) * 23'(fb_reg);
    assign q       = m_reg[PROD_W-1:RECIP_SHIFT];
    assign t_s     = sign_reg ? -signed'({1'b0, q}) : signed'({1'b0, q});
    assign new_s   = signed'({{2{x_reg[SAMPLE_W-1]}}, x_reg, 7'd0}) + 25'(t_s);
    assign new_neg = new_s[24];
    assign new_abs = new_neg ? (~unsigned'(new_s) + 25'd1) : unsigned'(new_s);
    assign p2      = 47'(p1_reg) * 47'(depth_reg);

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        wrapped_next   = wrapped_reg;
        fill_cnt_next  = fill_cnt_reg;
        out_valid_next = out_valid_reg;
        x_next         = x_reg;
        fill_next      = fill_reg;
        old_ok_next    = old_ok_reg;
        wr_addr_next   = wr_addr_reg;
        div_in_next    = div_in_reg;
        m_next         = m_reg;
        sign_next      = sign_reg;
        pass2_next     = pass2_reg;
        new_mag_next   = new_mag_reg;
        p1_next        = p1_reg;
        res_next       = res_reg;
        out_data_next  = out_data_reg;
        in_stall       = 1'b1;
        rd_en          = 1'b0;
        we             = 1'b0;
        wdata          = unsigned'(x_reg);

        if (out_valid_reg && !out_stall) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid) begin
                    x_next        = sample_in;
                    fill_next     = fill_now;
                    old_ok_next   = wrapped_reg || (rd_addr < pos_reg);
                    rd_en         = 1'b1;
                    wr_addr_next  = pos_reg;
                    pos_next      = pos_last ? '0 : pos_reg + ADDR_W'(1);
                    wrapped_next  = wrapped_reg | pos_last;
                    fill_cnt_next = fill_cnt_reg + CNT_W'(fill_now);
                    pass2_next    = 1'b0;
                    state_next    = ST_READ;
                end
            end
            ST_READ:
            begin
                div_in_next = fill_reg ? DIV_IN_W'(mul1) : {mul1[21:0], 7'd0};
                sign_next   = fill_reg ? x_neg : old_neg;
                state_next  = ST_DIV;
            end
            ST_DIV:
            begin
                m_next     = PROD_W'(div_in_reg) * PROD_W'(RECIP_100);
                state_next = pass2_reg ? ST_FIN : ST_MIX;
            end
            ST_MIX:
            begin
                we = 1'b1;
                if (fill_reg) begin
                    res_next   = sat_sm(sign_reg, q);
                    state_next = ST_EMIT;
                end else begin
                    wdata        = unsigned'(sat_sm(new_neg, Q_W'(new_abs[23:7])));
                    new_mag_next = new_abs[23:0];
                    sign_next    = new_neg;
                    state_next   = ST_VOL;
                end
            end
            ST_VOL:
            begin
                p1_next    = 31'(new_mag_reg) * 31'(vol_reg);
                state_next = ST_DEPTH;
            end
            ST_DEPTH:
            begin
                div_in_next = DIV_IN_W'(p2[46:22]);
                pass2_next  = 1'b1;
                state_next  = ST_DIV;
            end
            ST_FIN:
            begin
                res_next   = sat_sm(sign_reg, q);
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall) begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            wrapped_reg   <= 1'b0;
            fill_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
            delay_reg     <= DELAY_RST;
            fb_reg        <= FEEDBACK_RST;
            vol_reg       <= VOLUME_RST;
            depth_reg     <= DEPTH_RST;
        end else begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            wrapped_reg   <= wrapped_next;
            fill_cnt_reg  <= fill_cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                case (cfg_index)
                    REG_DELAY:    delay_reg <= cfg_data[DLY_W-1:0];
                    REG_FEEDBACK: fb_reg    <= cfg_data[PCT_W-1:0];
                    REG_VOLUME:   vol_reg   <= cfg_data[PCT_W-1:0];
                    REG_DEPTH:    depth_reg <= cfg_data[DEPTH_W-1:0];
                    default:      ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        fill_reg     <= fill_next;
        old_ok_reg   <= old_ok_next;
        wr_addr_reg  <= wr_addr_next;
        div_in_reg   <= div_in_next;
        m_reg        <= m_next;
        sign_reg     <= sign_next;
        pass2_reg    <= pass2_next;
        new_mag_reg  <= new_mag_next;
        p1_reg       <= p1_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    // delay memory, one read and one write port, registered read
    always_ff @(posedge clk)
    begin
        if (we) begin
            mem[wr_addr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = out_data_reg;

endmodule

// File: hw/rtl/fbecho_assert.sv
module fbecho_assert (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] sample_out
);

    logic [1:0] pend_reg, pend_next;
    logic       in_beat, out_beat;

    assign in_beat   = in_valid && !in_stall;
    assign out_beat  = out_valid && !out_stall;
    assign pend_next = pend_reg + 2'(in_beat) - 2'(out_beat);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    // no result without a beat still owed
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 2'd0)
        else $error("result with no beat outstanding");

    // one beat at work plus one waiting at the output at most
    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("more than two beats outstanding");

    // sequencer stays busy after a beat is taken
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> in_stall ##1 in_stall)
        else $error("input taken while busy");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sample_out))
        else $error("stalled output beat changed");

endmodule

bind feedback_echo_delay fbecho_assert u_fbecho_assert (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out)
);
